FILE: src/ftsr_pkg.sv
// Shared types, constants and helpers of the flat triangle scanline rasterizer.
package ftsr_pkg;

    localparam int SubpixelBits = 4;
    localparam int InvzFracBits = 24;
    localparam int ScreenBits   = 12;
    localparam int XFrac        = 16;
    localparam int NumW         = 50;
    localparam int DenW         = 34;
    localparam int MagW         = NumW - 1;
    localparam int DivSteps     = MagW;
    localparam int CntW         = $clog2(DivSteps + 1);
    localparam int QueueDepth   = 2;

    localparam logic signed [NumW-1:0] RcpNum = NumW'(64'd1 << (InvzFracBits + 8));

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic               cmd;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [23:0]        az;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [23:0]        bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [23:0]        cz;
        logic [31:0]        fill_color;
    } item_t;

    typedef struct packed
    {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [23:0]        z;
    } vtx_t;

    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_L_RT,
        ST_L_RM,
        ST_L_RB,
        ST_L_SX1,
        ST_L_SX2,
        ST_L_SZ1,
        ST_L_SZ2,
        ST_L_MUL,
        ST_L_CMP,
        ST_SEEK,
        ST_SP_DIV,
        ST_LW_SX,
        ST_LW_SZ,
        ST_TICK,
        ST_EMIT
    } state_t;

    function automatic logic signed [ScreenBits-1:0] row_of(input logic signed [15:0] y);
        logic [16:0]            mag;
        logic [ScreenBits-1:0]  r;
        mag = y[15] ? 17'(-$signed({y[15], y})) : 17'({y[15], y});
        r   = mag[15:SubpixelBits];
        return y[15] ? $signed(-r) : $signed(r);
    endfunction

    function automatic logic signed [15:0] col_of(input logic [31:0] x);
        logic [31:0] mag;
        logic [15:0] c;
        mag = x[31] ? (~x + 32'd1) : x;
        c   = mag[31:XFrac];
        return x[31] ? $signed(-c) : $signed(c);
    endfunction

endpackage

FILE: src/flat_triangle_scanline_rasterizer.sv
// Top level of the flat triangle scanline rasterizer.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, cmd, ax..cz, fill_color | load or tick beat in
//   out     | out_valid, out_ready, frag_*              | one fragment beat out
//
// A load takes 7 serial divisions of 49 divider steps each and the multiply and
// compare states, then the seek steps over empty rows, two divisions enter the
// lower half and one division opens each span.
// A tick inside a span passes the tick and emit states before its beat; one that
// ends a span adds the seek. A tick with no triangle is popped and dropped.
// Asynchronous active-low reset leaves the block with no triangle.
// A two-beat input queue keeps accepting while the output register stalls, until full.
module flat_triangle_scanline_rasterizer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic [23:0]        az,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic [23:0]        bz,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] cy,
    input  logic [23:0]        cz,
    input  logic [31:0]        fill_color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] frag_x,
    output logic signed [11:0] frag_y,
    output logic [31:0]        frag_inv_z,
    output logic [31:0]        frag_color,
    output logic               frag_last
);

    ftsr_pkg::item_t in_item;
    ftsr_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;
    logic [11:0]     fx;
    logic [11:0]     fy;

    assign in_item = '{cmd: cmd, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz,
                       cx: cx, cy: cy, cz: cz, fill_color: fill_color};
    assign frag_x  = $signed(fx);
    assign frag_y  = $signed(fy);

    ftsr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ftsr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frag_x     (fx),
        .frag_y     (fy),
        .frag_inv_z (frag_inv_z),
        .frag_color (frag_color),
        .frag_last  (frag_last)
    );

endmodule

FILE: src/ftsr_front.sv
// Input queue of the rasterizer: accepts beats and holds them for the sequencer.
module ftsr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ftsr_pkg::item_t     in_item,
    output logic                q_valid,
    output ftsr_pkg::item_t     q_item,
    input  logic                q_pop
);

    ftsr_pkg::item_t mem [ftsr_pkg::QueueDepth];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign in_ready = (count_reg != 2'(ftsr_pkg::QueueDepth));
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: src/ftsr_div.sv
// Bit-serial signed divider with slope and reciprocal result modes.
module ftsr_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                rcp,
    input  logic signed [ftsr_pkg::NumW-1:0]    num,
    input  logic signed [ftsr_pkg::DenW-1:0]    den,
    output logic                                done,
    output logic [31:0]                         quo
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ftsr_pkg::CntW-1:0]      cnt_reg;
    logic [ftsr_pkg::MagW-1:0]      q_reg;
    logic [ftsr_pkg::DenW-1:0]      rem_reg;
    logic [ftsr_pkg::DenW-1:0]      dmag_reg;
    logic                           neg_reg;
    logic                           dz_reg;
    logic                           rcp_reg;
    logic [31:0]                    quo_reg;
    logic [ftsr_pkg::NumW-1:0]      nabs;
    logic [ftsr_pkg::DenW-1:0]      dabs;
    logic [ftsr_pkg::DenW:0]        shifted;
    logic                           fits;
    logic [ftsr_pkg::DenW-1:0]      rem_next;
    logic [ftsr_pkg::MagW-1:0]      q_next;
    logic [ftsr_pkg::MagW-1:0]      sq;

    assign nabs     = num[ftsr_pkg::NumW-1] ? ftsr_pkg::NumW'(-num) : ftsr_pkg::NumW'(num);
    assign dabs     = den[ftsr_pkg::DenW-1] ? ftsr_pkg::DenW'(-den) : ftsr_pkg::DenW'(den);
    assign shifted  = {rem_reg, q_reg[ftsr_pkg::MagW-1]};
    assign fits     = (shifted >= {1'b0, dmag_reg});
    assign rem_next = fits ? ftsr_pkg::DenW'(shifted - {1'b0, dmag_reg})
                           : shifted[ftsr_pkg::DenW-1:0];
    assign q_next   = {q_reg[ftsr_pkg::MagW-2:0], fits};
    assign sq       = neg_reg ? (~q_next + ftsr_pkg::MagW'(1)) : q_next;
    assign done     = done_reg;
    assign quo      = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ftsr_pkg::CntW'(1);
                if (cnt_reg == ftsr_pkg::CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ftsr_pkg::CntW'(ftsr_pkg::DivSteps);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == ftsr_pkg::CntW'(1))
            begin
                if (rcp_reg)
                begin
                    quo_reg <= (dz_reg || (q_next[ftsr_pkg::MagW-1:32] != '0))
                               ? 32'hFFFF_FFFF : q_next[31:0];
                end
                else
                begin
                    quo_reg <= dz_reg ? 32'd0 : sq[31:0];
                end
            end
        end
        else if (start)
        begin
            rem_reg  <= '0;
            q_reg    <= nabs[ftsr_pkg::MagW-1:0];
            dmag_reg <= dabs;
            neg_reg  <= num[ftsr_pkg::NumW-1] ^ den[ftsr_pkg::DenW-1];
            dz_reg   <= (den == '0);
            rcp_reg  <= rcp;
        end
    end

endmodule

FILE: src/ftsr_back.sv
// Setup and scan sequencer of the rasterizer with its output register.
module ftsr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ftsr_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         frag_x,
    output logic [11:0]         frag_y,
    output logic [31:0]         frag_inv_z,
    output logic [31:0]         frag_color,
    output logic                frag_last
);

    ftsr_pkg::state_t   state_reg, state_next;
    logic               go_reg, go_next;
    logic               active_reg, active_next;
    logic               emit_reg, emit_next;
    logic               ov_reg, ov_next;

    ftsr_pkg::vtx_t     vt_reg, vt_next, vm_reg, vm_next, vb_reg, vb_next;
    logic [31:0]        color_reg, color_next;
    logic [31:0]        izt_reg, izt_next, izm_reg, izm_next, izb_reg, izb_next;
    logic [31:0]        sx1_reg, sx1_next, sx2_reg, sx2_next;
    logic [31:0]        sz1_reg, sz1_next, sz2_reg, sz2_next;
    logic signed [33:0] p1_reg, p1_next, p2_reg, p2_next;
    logic               lower_reg, lower_next, sleft_reg, sleft_next;
    logic [31:0]        ssx_reg, ssx_next, sex_reg, sex_next;
    logic [31:0]        ssi_reg, ssi_next, sei_reg, sei_next;
    logic [31:0]        elx_reg, elx_next, erx_reg, erx_next;
    logic [31:0]        eli_reg, eli_next, eri_reg, eri_next;
    logic signed [11:0] row_reg, row_next;
    logic signed [15:0] col_reg, col_next;
    logic [31:0]        iz_reg, iz_next, izs_reg, izs_next;
    logic [11:0]        px_reg, px_next, py_reg, py_next;
    logic [31:0]        piz_reg, piz_next;
    logic [11:0]        ox_reg, ox_next, oy_reg, oy_next;
    logic [31:0]        oiz_reg, oiz_next, ocol_reg, ocol_next;
    logic               olast_reg, olast_next;

    logic                                div_start;
    logic                                div_rcp;
    logic signed [ftsr_pkg::NumW-1:0]    div_num;
    logic signed [ftsr_pkg::DenW-1:0]    div_den;
    logic                                div_done;
    logic [31:0]                         div_quo;

    ftsr_pkg::vtx_t     s0, s1, s2, tv;
    logic signed [16:0] dx1, dy1, dx2, dy2, dxl, dyl;
    logic signed [32:0] dzt_m, dzt_b, dzm_b, dzs;
    logic signed [32:0] span_w;
    logic signed [11:0] limit;
    logic signed [15:0] c0, c1;
    logic signed [15:0] col_inc;

    ftsr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .rcp   (div_rcp),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid  = ov_reg;
    assign frag_x     = ox_reg;
    assign frag_y     = oy_reg;
    assign frag_inv_z = oiz_reg;
    assign frag_color = ocol_reg;
    assign frag_last  = olast_reg;

    assign dx1    = 17'(vm_reg.x) - 17'(vt_reg.x);
    assign dy1    = 17'(vm_reg.y) - 17'(vt_reg.y);
    assign dx2    = 17'(vb_reg.x) - 17'(vt_reg.x);
    assign dy2    = 17'(vb_reg.y) - 17'(vt_reg.y);
    assign dxl    = 17'(vb_reg.x) - 17'(vm_reg.x);
    assign dyl    = 17'(vb_reg.y) - 17'(vm_reg.y);
    assign dzt_m  = $signed({1'b0, izm_reg}) - $signed({1'b0, izt_reg});
    assign dzt_b  = $signed({1'b0, izb_reg}) - $signed({1'b0, izt_reg});
    assign dzm_b  = $signed({1'b0, izb_reg}) - $signed({1'b0, izm_reg});
    assign dzs    = $signed({1'b0, sei_reg}) - $signed({1'b0, ssi_reg});
    assign span_w = 33'($signed(sex_reg)) - 33'($signed(ssx_reg));
    assign limit  = ftsr_pkg::row_of(lower_reg ? vb_reg.y : vm_reg.y);
    assign c0     = ftsr_pkg::col_of(ssx_reg);
    assign c1     = ftsr_pkg::col_of(sex_reg);
    assign col_inc = col_reg + 16'sd1;

    always_comb
    begin
        tv = q_item.ay < q_item.ay ? '0 : '0;
        s0 = '{x: q_item.ax, y: q_item.ay, z: q_item.az};
        s1 = '{x: q_item.bx, y: q_item.by, z: q_item.bz};
        s2 = '{x: q_item.cx, y: q_item.cy, z: q_item.cz};
        if (s1.y < s0.y)
        begin
            tv = s1; s1 = s0; s0 = tv;
        end
        if (s2.y < s0.y)
        begin
            tv = s0; s0 = s2; s2 = tv;
        end
        if (s1.y < s2.y)
        begin
            tv = s1; s1 = s2; s2 = tv;
        end
    end

    always_comb
    begin
        div_rcp = 1'b0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ftsr_pkg::ST_L_RT:
            begin
                div_rcp = 1'b1; div_num = ftsr_pkg::RcpNum; div_den = 34'(vt_reg.z);
            end
            ftsr_pkg::ST_L_RM:
            begin
                div_rcp = 1'b1; div_num = ftsr_pkg::RcpNum; div_den = 34'(vm_reg.z);
            end
            ftsr_pkg::ST_L_RB:
            begin
                div_rcp = 1'b1; div_num = ftsr_pkg::RcpNum; div_den = 34'(vb_reg.z);
            end
            ftsr_pkg::ST_L_SX1:
            begin
                div_num = 50'($signed({dx1, 16'd0})); div_den = 34'(dy1);
            end
            ftsr_pkg::ST_L_SX2:
            begin
                div_num = 50'($signed({dx2, 16'd0})); div_den = 34'(dy2);
            end
            ftsr_pkg::ST_L_SZ1:
            begin
                div_num = 50'($signed({dzt_m, 4'd0})); div_den = 34'(dy1);
            end
            ftsr_pkg::ST_L_SZ2:
            begin
                div_num = 50'($signed({dzt_b, 4'd0})); div_den = 34'(dy2);
            end
            ftsr_pkg::ST_LW_SX:
            begin
                div_num = 50'($signed({dxl, 16'd0})); div_den = 34'(dyl);
            end
            ftsr_pkg::ST_LW_SZ:
            begin
                div_num = 50'($signed({dzm_b, 4'd0})); div_den = 34'(dyl);
            end
            ftsr_pkg::ST_SP_DIV:
            begin
                div_num = 50'($signed({dzs, 16'd0})); div_den = 34'(span_w);
            end
            default:
            begin
                div_rcp = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        go_next     = go_reg;
        active_next = active_reg;
        emit_next   = emit_reg;
        ov_next     = ov_reg && !out_ready;
        vt_next = vt_reg; vm_next = vm_reg; vb_next = vb_reg;
        color_next = color_reg;
        izt_next = izt_reg; izm_next = izm_reg; izb_next = izb_reg;
        sx1_next = sx1_reg; sx2_next = sx2_reg; sz1_next = sz1_reg; sz2_next = sz2_reg;
        p1_next = p1_reg; p2_next = p2_reg;
        lower_next = lower_reg; sleft_next = sleft_reg;
        ssx_next = ssx_reg; sex_next = sex_reg; ssi_next = ssi_reg; sei_next = sei_reg;
        elx_next = elx_reg; erx_next = erx_reg; eli_next = eli_reg; eri_next = eri_reg;
        row_next = row_reg; col_next = col_reg; iz_next = iz_reg; izs_next = izs_reg;
        px_next = px_reg; py_next = py_reg; piz_next = piz_reg;
        ox_next = ox_reg; oy_next = oy_reg; oiz_next = oiz_reg; ocol_next = ocol_reg;
        olast_next = olast_reg;
        q_pop     = 1'b0;
        div_start = 1'b0;

        case (state_reg)
            ftsr_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.cmd == ftsr_pkg::CMD_LOAD)
                    begin
                        vt_next    = s0;
                        vm_next    = s2;
                        vb_next    = s1;
                        color_next = q_item.fill_color;
                        emit_next  = 1'b0;
                        state_next = ftsr_pkg::ST_L_RT;
                    end
                    else if (active_reg)
                    begin
                        state_next = ftsr_pkg::ST_TICK;
                    end
                end
            end
            ftsr_pkg::ST_L_RT, ftsr_pkg::ST_L_RM, ftsr_pkg::ST_L_RB,
            ftsr_pkg::ST_L_SX1, ftsr_pkg::ST_L_SX2, ftsr_pkg::ST_L_SZ1,
            ftsr_pkg::ST_L_SZ2, ftsr_pkg::ST_LW_SX, ftsr_pkg::ST_LW_SZ,
            ftsr_pkg::ST_SP_DIV:
            begin
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (div_done)
                begin
                    go_next = 1'b0;
                    case (state_reg)
                        ftsr_pkg::ST_L_RT:
                        begin
                            izt_next = div_quo; state_next = ftsr_pkg::ST_L_RM;
                        end
                        ftsr_pkg::ST_L_RM:
                        begin
                            izm_next = div_quo; state_next = ftsr_pkg::ST_L_RB;
                        end
                        ftsr_pkg::ST_L_RB:
                        begin
                            izb_next = div_quo; state_next = ftsr_pkg::ST_L_SX1;
                        end
                        ftsr_pkg::ST_L_SX1:
                        begin
                            sx1_next = div_quo; state_next = ftsr_pkg::ST_L_SX2;
                        end
                        ftsr_pkg::ST_L_SX2:
                        begin
                            sx2_next = div_quo; state_next = ftsr_pkg::ST_L_SZ1;
                        end
                        ftsr_pkg::ST_L_SZ1:
                        begin
                            sz1_next = div_quo; state_next = ftsr_pkg::ST_L_SZ2;
                        end
                        ftsr_pkg::ST_L_SZ2:
                        begin
                            sz2_next = div_quo; state_next = ftsr_pkg::ST_L_MUL;
                        end
                        ftsr_pkg::ST_LW_SX:
                        begin
                            sx1_next = div_quo; state_next = ftsr_pkg::ST_LW_SZ;
                        end
                        ftsr_pkg::ST_LW_SZ:
                        begin
                            if (sleft_reg)
                            begin
                                elx_next = sx1_reg;
                                eli_next = div_quo;
                                ssx_next = 32'(vm_reg.x) << (ftsr_pkg::XFrac - ftsr_pkg::SubpixelBits);
                                ssi_next = izm_reg;
                            end
                            else
                            begin
                                erx_next = sx1_reg;
                                eri_next = div_quo;
                                sex_next = 32'(vm_reg.x) << (ftsr_pkg::XFrac - ftsr_pkg::SubpixelBits);
                                sei_next = izm_reg;
                            end
                            row_next   = ftsr_pkg::row_of(vm_reg.y);
                            lower_next = 1'b1;
                            state_next = ftsr_pkg::ST_SEEK;
                        end
                        default:
                        begin
                            izs_next   = div_quo;
                            state_next = emit_reg ? ftsr_pkg::ST_EMIT : ftsr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ftsr_pkg::ST_L_MUL:
            begin
                p1_next    = dx1 * dy2;
                p2_next    = dx2 * dy1;
                state_next = ftsr_pkg::ST_L_CMP;
            end
            ftsr_pkg::ST_L_CMP:
            begin
                sleft_next = (p1_reg < p2_reg);
                if (p1_reg < p2_reg)
                begin
                    elx_next = sx1_reg; erx_next = sx2_reg;
                    eli_next = sz1_reg; eri_next = sz2_reg;
                end
                else
                begin
                    elx_next = sx2_reg; erx_next = sx1_reg;
                    eli_next = sz2_reg; eri_next = sz1_reg;
                end
                ssx_next    = 32'(vt_reg.x) << (ftsr_pkg::XFrac - ftsr_pkg::SubpixelBits);
                sex_next    = 32'(vt_reg.x) << (ftsr_pkg::XFrac - ftsr_pkg::SubpixelBits);
                ssi_next    = izt_reg;
                sei_next    = izt_reg;
                row_next    = ftsr_pkg::row_of(vt_reg.y);
                lower_next  = 1'b0;
                active_next = 1'b1;
                state_next  = ftsr_pkg::ST_SEEK;
            end
            ftsr_pkg::ST_SEEK:
            begin
                if (row_reg < limit)
                begin
                    if (c0 < c1)
                    begin
                        col_next   = c0;
                        iz_next    = ssi_reg;
                        state_next = ftsr_pkg::ST_SP_DIV;
                    end
                    else
                    begin
                        ssx_next = ssx_reg + elx_reg;
                        sex_next = sex_reg + erx_reg;
                        ssi_next = ssi_reg + eli_reg;
                        sei_next = sei_reg + eri_reg;
                        row_next = row_reg + 12'sd1;
                    end
                end
                else if (!lower_reg)
                begin
                    state_next = ftsr_pkg::ST_LW_SX;
                end
                else
                begin
                    active_next = 1'b0;
                    state_next  = emit_reg ? ftsr_pkg::ST_EMIT : ftsr_pkg::ST_IDLE;
                end
            end
            ftsr_pkg::ST_TICK:
            begin
                px_next   = col_reg[11:0];
                py_next   = row_reg;
                piz_next  = iz_reg;
                col_next  = col_inc;
                iz_next   = iz_reg + izs_reg;
                emit_next = 1'b1;
                if (col_inc >= c1)
                begin
                    ssx_next   = ssx_reg + elx_reg;
                    sex_next   = sex_reg + erx_reg;
                    ssi_next   = ssi_reg + eli_reg;
                    sei_next   = sei_reg + eri_reg;
                    row_next   = row_reg + 12'sd1;
                    state_next = ftsr_pkg::ST_SEEK;
                end
                else
                begin
                    state_next = ftsr_pkg::ST_EMIT;
                end
            end
            ftsr_pkg::ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ox_next    = px_reg;
                    oy_next    = py_reg;
                    oiz_next   = piz_reg;
                    ocol_next  = color_reg;
                    olast_next = !active_reg;
                    emit_next  = 1'b0;
                    state_next = ftsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ftsr_pkg::ST_IDLE;
            go_reg     <= 1'b0;
            active_reg <= 1'b0;
            emit_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            go_reg     <= go_next;
            active_reg <= active_next;
            emit_reg   <= emit_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vt_reg <= vt_next; vm_reg <= vm_next; vb_reg <= vb_next;
        color_reg <= color_next;
        izt_reg <= izt_next; izm_reg <= izm_next; izb_reg <= izb_next;
        sx1_reg <= sx1_next; sx2_reg <= sx2_next; sz1_reg <= sz1_next; sz2_reg <= sz2_next;
        p1_reg <= p1_next; p2_reg <= p2_next;
        lower_reg <= lower_next; sleft_reg <= sleft_next;
        ssx_reg <= ssx_next; sex_reg <= sex_next; ssi_reg <= ssi_next; sei_reg <= sei_next;
        elx_reg <= elx_next; erx_reg <= erx_next; eli_reg <= eli_next; eri_reg <= eri_next;
        row_reg <= row_next; col_reg <= col_next; iz_reg <= iz_next; izs_reg <= izs_next;
        px_reg <= px_next; py_reg <= py_next; piz_reg <= piz_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oiz_reg <= oiz_next; ocol_reg <= ocol_next;
        olast_reg <= olast_next;
    end

endmodule

FILE: verif/flat_triangle_scanline_rasterizer_checker.sv
// Fragment predictor and scoreboard for the flat triangle scanline rasterizer.
`timescale 1ns / 100ps
module flat_triangle_scanline_rasterizer_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic [23:0]        az,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic [23:0]        bz,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] cy,
    input  logic [23:0]        cz,
    input  logic [31:0]        fill_color,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [11:0] frag_x,
    input  logic signed [11:0] frag_y,
    input  logic [31:0]        frag_inv_z,
    input  logic [31:0]        frag_color,
    input  logic               frag_last,
    output int                 errors,
    output int                 outstanding
);

    typedef struct
    {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [31:0]        iz;
        logic [31:0]        color;
        logic               last;
    } frag_t;

    frag_t       frags_due[$];
    logic        tri_active;
    logic        in_lower;
    logic        short_on_left;
    longint      vert_x[3];
    longint      vert_y[3];
    logic [23:0] vert_z[3];
    logic [31:0] left_x;
    logic [31:0] right_x;
    logic [31:0] left_iz;
    logic [31:0] right_iz;
    logic [31:0] row_step[4];
    int          row_now;
    int          col_now;
    logic [31:0] iz_now;
    logic [31:0] iz_inc;
    logic [31:0] tri_color;

    function automatic logic [31:0] inv_depth(input logic [23:0] z);
        longint q;
        if (z == 0)
            return '1;
        q = (longint'(1) <<< (ftsr_pkg::InvzFracBits + 8)) / longint'(z);
        return (q > 64'sh0FFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function automatic logic [31:0] div_tz(input longint num, input longint den);
        longint q;
        if (den == 0)
            return '0;
        q = num / den;
        return q[31:0];
    endfunction

    function automatic longint shift_tz(input longint v, input int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic int pixel_col(input logic [31:0] xq);
        return int'(shift_tz(longint'($signed(xq)), ftsr_pkg::XFrac));
    endfunction

    function automatic int pixel_row(input longint y);
        return int'(shift_tz(y, ftsr_pkg::SubpixelBits));
    endfunction

    function automatic logic [31:0] x_fixed(input longint x);
        return 32'(x * (longint'(1) <<< (ftsr_pkg::XFrac - ftsr_pkg::SubpixelBits)));
    endfunction

    function void step_rows();
        left_x   += row_step[0];
        right_x  += row_step[1];
        left_iz  += row_step[2];
        right_iz += row_step[3];
        row_now++;
    endfunction

    function void start_lower();
        longint      dy;
        logic [31:0] izm;
        logic [31:0] sx;
        logic [31:0] sz;
        dy  = vert_y[2] - vert_y[1];
        izm = inv_depth(vert_z[1]);
        sx  = div_tz((vert_x[2] - vert_x[1]) * (longint'(1) <<< ftsr_pkg::XFrac), dy);
        sz  = div_tz((longint'(inv_depth(vert_z[2])) - longint'(izm))
                     * (longint'(1) <<< ftsr_pkg::SubpixelBits), dy);
        in_lower = 1'b1;
        if (short_on_left)
        begin
            row_step[0] = sx;
            row_step[2] = sz;
            left_x      = x_fixed(vert_x[1]);
            left_iz     = izm;
        end
        else
        begin
            row_step[1] = sx;
            row_step[3] = sz;
            right_x     = x_fixed(vert_x[1]);
            right_iz    = izm;
        end
        row_now = pixel_row(vert_y[1]);
    endfunction

    function automatic bit open_row();
        int c0;
        int c1;
        c0 = pixel_col(left_x);
        c1 = pixel_col(right_x);
        if (c0 >= c1)
            return 1'b0;
        iz_inc = div_tz((longint'(right_iz) - longint'(left_iz))
                        * (longint'(1) <<< ftsr_pkg::XFrac),
                        longint'($signed(right_x)) - longint'($signed(left_x)));
        col_now = c0;
        iz_now  = left_iz;
        return 1'b1;
    endfunction

    function void find_next();
        int stop_row;
        forever
        begin
            stop_row = pixel_row(in_lower ? vert_y[2] : vert_y[1]);
            if (row_now < stop_row)
            begin
                if (open_row())
                    return;
                step_rows();
            end
            else if (!in_lower)
                start_lower();
            else
            begin
                tri_active = 1'b0;
                return;
            end
        end
    endfunction

    function void load_triangle();
        longint      x[3];
        longint      y[3];
        logic [23:0] z[3];
        longint      tx;
        longint      ty;
        logic [23:0] tz;
        longint      dx1;
        longint      dy1;
        longint      dx2;
        longint      dy2;
        logic [31:0] iz0;
        logic [31:0] sx1;
        logic [31:0] sx2;
        logic [31:0] sz1;
        logic [31:0] sz2;
        x[0] = ax; y[0] = ay; z[0] = az;
        x[1] = bx; y[1] = by; z[1] = bz;
        x[2] = cx; y[2] = cy; z[2] = cz;
        if (y[1] < y[0])
        begin
            tx = x[1]; ty = y[1]; tz = z[1];
            x[1] = x[0]; y[1] = y[0]; z[1] = z[0];
            x[0] = tx; y[0] = ty; z[0] = tz;
        end
        if (y[2] < y[0])
        begin
            tx = x[0]; ty = y[0]; tz = z[0];
            x[0] = x[2]; y[0] = y[2]; z[0] = z[2];
            x[2] = tx; y[2] = ty; z[2] = tz;
        end
        if (y[1] < y[2])
        begin
            tx = x[1]; ty = y[1]; tz = z[1];
            x[1] = x[2]; y[1] = y[2]; z[1] = z[2];
            x[2] = tx; y[2] = ty; z[2] = tz;
        end
        vert_x[0] = x[0]; vert_y[0] = y[0]; vert_z[0] = z[0];
        vert_x[1] = x[2]; vert_y[1] = y[2]; vert_z[1] = z[2];
        vert_x[2] = x[1]; vert_y[2] = y[1]; vert_z[2] = z[1];
        iz0 = inv_depth(z[0]);
        dx1 = x[2] - x[0]; dy1 = y[2] - y[0];
        dx2 = x[1] - x[0]; dy2 = y[1] - y[0];
        sx1 = div_tz(dx1 * (longint'(1) <<< ftsr_pkg::XFrac), dy1);
        sx2 = div_tz(dx2 * (longint'(1) <<< ftsr_pkg::XFrac), dy2);
        sz1 = div_tz((longint'(inv_depth(z[2])) - longint'(iz0))
                     * (longint'(1) <<< ftsr_pkg::SubpixelBits), dy1);
        sz2 = div_tz((longint'(inv_depth(z[1])) - longint'(iz0))
                     * (longint'(1) <<< ftsr_pkg::SubpixelBits), dy2);
        short_on_left = (dx1 * dy2) < (dx2 * dy1);
        if (short_on_left)
        begin
            row_step[0] = sx1; row_step[1] = sx2; row_step[2] = sz1; row_step[3] = sz2;
        end
        else
        begin
            row_step[0] = sx2; row_step[1] = sx1; row_step[2] = sz2; row_step[3] = sz1;
        end
        left_x     = x_fixed(x[0]);
        right_x    = left_x;
        left_iz    = iz0;
        right_iz   = iz0;
        row_now    = pixel_row(y[0]);
        tri_color  = fill_color;
        in_lower   = 1'b0;
        tri_active = 1'b1;
        find_next();
    endfunction

    function void next_fragment();
        frag_t f;
        f.x     = 12'(col_now);
        f.y     = 12'(row_now);
        f.iz    = iz_now;
        f.color = tri_color;
        col_now++;
        iz_now += iz_inc;
        if (col_now >= pixel_col(right_x))
        begin
            step_rows();
            find_next();
        end
        f.last = !tri_active;
        frags_due.push_back(f);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors        <= 0;
            tri_active    = 1'b0;
            in_lower      = 1'b0;
            short_on_left = 1'b0;
            left_x        = '0;
            right_x       = '0;
            left_iz       = '0;
            right_iz      = '0;
            row_step      = '{default: '0};
            row_now       = 0;
            col_now       = 0;
            iz_now        = '0;
            iz_inc        = '0;
            tri_color     = '0;
            frags_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frags_due.size() == 0)
                begin
                    $error("fragment beat with none expected: x=%0d y=%0d", frag_x, frag_y);
                    errors <= errors + 1;
                end
                else
                begin
                    frag_t f;
                    f = frags_due.pop_front();
                    if (frag_x !== f.x || frag_y !== f.y || frag_inv_z !== f.iz
                        || frag_color !== f.color || frag_last !== f.last)
                        errors <= errors + 1;
                    if (frag_x !== f.x)
                        $error("frag_x: expected %0d, actual %0d", f.x, frag_x);
                    if (frag_y !== f.y)
                        $error("frag_y: expected %0d, actual %0d", f.y, frag_y);
                    if (frag_inv_z !== f.iz)
                        $error("frag_inv_z: expected %h, actual %h", f.iz, frag_inv_z);
                    if (frag_color !== f.color)
                        $error("frag_color: expected %h, actual %h", f.color, frag_color);
                    if (frag_last !== f.last)
                        $error("frag_last: expected %b, actual %b", f.last, frag_last);
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == ftsr_pkg::CMD_LOAD)
                    load_triangle();
                else if (tri_active)
                    next_fragment();
            end
        end
    end

    assign outstanding = frags_due.size();

endmodule

FILE: verif/flat_triangle_scanline_rasterizer_test.sv
// Stimulus, receiver stalls and verdict for the flat triangle scanline rasterizer.
`timescale 1ns / 100ps
module flat_triangle_scanline_rasterizer_test;

    localparam int IdleLimit = 40000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [23:0]        az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [23:0]        bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [23:0]        cz;
    logic [31:0]        fill_color;
    logic               out_valid;
    logic               out_ready;
    logic signed [11:0] frag_x;
    logic signed [11:0] frag_y;
    logic [31:0]        frag_inv_z;
    logic [31:0]        frag_color;
    logic               frag_last;
    int                 errors;
    int                 outstanding;
    int                 burst_left;
    int                 idle_cycles;
    int                 hold_left;
    int                 ready_phase;
    int                 ready_mode;
    bit                 hold_req;
    bit                 hold_done;

    flat_triangle_scanline_rasterizer uut (.*);

    flat_triangle_scanline_rasterizer_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_beat(input ftsr_pkg::item_t it);
        int gap;
        in_valid   <= 1'b1;
        cmd        <= it.cmd;
        ax         <= it.ax;
        ay         <= it.ay;
        az         <= it.az;
        bx         <= it.bx;
        by         <= it.by;
        bz         <= it.bz;
        cx         <= it.cx;
        cy         <= it.cy;
        cz         <= it.cz;
        fill_color <= it.fill_color;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic ftsr_pkg::item_t tick_beat();
        ftsr_pkg::item_t it;
        logic [223:0]    raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(ftsr_pkg::item_t)-1:0];
        it.cmd = ftsr_pkg::CMD_TICK;
        return it;
    endfunction

    function automatic ftsr_pkg::item_t tri_beat(input int xa, input int ya, input int za,
                                                 input int xb, input int yb, input int zb,
                                                 input int xc, input int yc, input int zc,
                                                 input logic [31:0] color);
        ftsr_pkg::item_t it;
        it.cmd = ftsr_pkg::CMD_LOAD;
        it.ax = 16'(xa); it.ay = 16'(ya); it.az = 24'(za);
        it.bx = 16'(xb); it.by = 16'(yb); it.bz = 24'(zb);
        it.cx = 16'(xc); it.cy = 16'(yc); it.cz = 24'(zc);
        it.fill_color = color;
        return it;
    endfunction

    function automatic int near(input int base, input int spread);
        int v;
        if ($urandom_range(0, 19) == 0)
            return $signed(16'($urandom));
        v = base + $urandom_range(0, 2 * spread) - spread;
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int rand_depth();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                            : $urandom_range(1, 24'hFFFFFF);
    endfunction

    function automatic ftsr_pkg::item_t rand_tri();
        int bx0;
        int by0;
        int sp;
        bx0 = $signed(16'($urandom));
        by0 = $signed(16'($urandom));
        sp  = ($urandom_range(0, 9) == 0) ? 400 : 96;
        return tri_beat(near(bx0, sp), near(by0, sp), rand_depth(),
                        near(bx0, sp), near(by0, sp), rand_depth(),
                        near(bx0, sp), near(by0, sp), rand_depth(), $urandom);
    endfunction

    initial
    begin
        int sent;
        int ticks;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= ftsr_pkg::CMD_TICK;
        ax         <= '0;
        ay         <= '0;
        az         <= 24'd1;
        bx         <= '0;
        by         <= '0;
        bz         <= 24'd1;
        cx         <= '0;
        cy         <= '0;
        cz         <= 24'd1;
        fill_color <= '0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(tick_beat());
        send_beat(tri_beat(-32768, -32768, 1, 32767, -32768, 24'hFFFFFF,
                           0, 32767, 2, 32'hFFFF_FFFF));
        repeat (3) send_beat(tick_beat());
        send_beat(tri_beat(0, 16, 100, 64, 16, 200, 32, 16, 300, 32'h1234_5678));
        send_beat(tick_beat());
        send_beat(tri_beat(0, 0, 256, 80, 0, 512, 40, 64, 1024, 32'hA5A5_A5A5));
        repeat (4) send_beat(tick_beat());
        send_beat(tri_beat(40, 0, 256, 0, 64, 512, 80, 64, 1024, 32'h5A5A_5A5A));
        repeat (4) send_beat(tick_beat());
        send_beat(tri_beat(5, 0, 300, 6, 40, 300, 5, 80, 300, 32'h0));
        send_beat(tick_beat());
        send_beat(tri_beat(-20, -20, 4096, 30, -3, 70000, -7, 30, 9000, 32'hCAFE_0001));
        repeat (4) send_beat(tick_beat());

        hold_req = 1'b1;
        sent = 0;
        while (sent < 1600)
        begin
            send_beat(rand_tri());
            ticks = $urandom_range(0, 45);
            repeat (ticks) send_beat(tick_beat());
            sent += ticks + 1;
        end
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("flat_triangle_scanline_rasterizer_test: PASS");
        else
            $display("flat_triangle_scanline_rasterizer_test: FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            hold_left   = 0;
            hold_done   = 1'b0;
            ready_phase = 0;
            ready_mode  = 0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 500;
            out_ready <= 1'b0;
        end
        else
        begin
            if (ready_phase == 0)
            begin
                ready_phase = $urandom_range(16, 96);
                ready_mode  = $urandom_range(0, 2);
            end
            ready_phase--;
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("flat_triangle_scanline_rasterizer_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: filelist.f
src/ftsr_pkg.sv
src/ftsr_front.sv
src/ftsr_div.sv
src/ftsr_back.sv
src/flat_triangle_scanline_rasterizer.sv
verif/flat_triangle_scanline_rasterizer_checker.sv
verif/flat_triangle_scanline_rasterizer_test.sv
